>>> src/can_fd_tx_element_framer_macros.svh
// Assertion macros for the framer RTL.
`ifndef CAN_FD_TX_ELEMENT_FRAMER_MACROS_SVH
`define CAN_FD_TX_ELEMENT_FRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define CFDTX_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("framer check failed");
`define CFDTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("framer sequence check failed");
`else
`define CFDTX_ASSERT(lbl, clk, rst_n, prop)
`define CFDTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/cfdtx_pkg.sv
package cfdtx_pkg;

	localparam int unsigned MRAM_BASE_DEF      = 32768;
	localparam int unsigned MAX_TX_BUFFERS_DEF = 32;
	localparam int unsigned WRITE_OPCODE_DEF   = 97;

	localparam int unsigned APB_AW = 4;

	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_DATA   = 1'b1;

	localparam logic [15:0] OFFSET_RST = 16'd0;
	localparam logic [5:0]  COUNT_RST  = 6'd32;
	localparam logic [2:0]  DSIZE_RST  = 3'd0;

	typedef enum logic [1:0] {
		REG_OFFSET = 2'd0,
		REG_COUNT  = 2'd1,
		REG_DSIZE  = 2'd2
	} cfg_reg_e;

	typedef struct packed {
		logic [2:0][31:0] words;
		logic             three;
		logic             last;
		logic             err;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	function automatic logic [6:0] elem_data_bytes(input logic [2:0] code);
		logic [6:0] b;
		case (code)
			3'd0:    b = 7'd8;
			3'd1:    b = 7'd12;
			3'd2:    b = 7'd16;
			3'd3:    b = 7'd20;
			3'd4:    b = 7'd24;
			3'd5:    b = 7'd32;
			3'd6:    b = 7'd48;
			default: b = 7'd64;
		endcase
		return b;
	endfunction

	function automatic logic [6:0] dlc_bytes(input logic [3:0] dlc);
		logic [6:0] b;
		case (dlc)
			4'd9:    b = 7'd12;
			4'd10:   b = 7'd16;
			4'd11:   b = 7'd20;
			4'd12:   b = 7'd24;
			4'd13:   b = 7'd32;
			4'd14:   b = 7'd48;
			4'd15:   b = 7'd64;
			default: b = {3'b000, dlc};
		endcase
		return b;
	endfunction

endpackage

>>> src/cfdtx_item_if.sv
interface cfdtx_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [4:0]  tx_buf_idx;
	logic [28:0] can_id;
	logic        extended;
	logic        remote;
	logic        error_state_ind;
	logic [3:0]  dlc;
	logic        bit_rate_switch;
	logic        fd_format;
	logic        event_fifo_ctrl;
	logic [7:0]  message_marker;
	logic [31:0] data_word;

	modport source (
		output valid, cmd, tx_buf_idx, can_id, extended, remote, error_state_ind, dlc,
			bit_rate_switch, fd_format, event_fifo_ctrl, message_marker, data_word,
		input ready
	);
	modport sink (
		input valid, cmd, tx_buf_idx, can_id, extended, remote, error_state_ind, dlc,
			bit_rate_switch, fd_format, event_fifo_ctrl, message_marker, data_word,
		output ready
	);
endinterface

>>> src/cfdtx_result_if.sv
interface cfdtx_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] spi_word;
	logic        last;
	logic        error;

	modport source (output valid, spi_word, last, error, input ready);
	modport sink (input valid, spi_word, last, error, output ready);
endinterface

>>> src/cfdtx_front.sv
module cfdtx_front
	import cfdtx_pkg::*;
#(
	parameter int unsigned MRAM_BASE      = MRAM_BASE_DEF,
	parameter int unsigned MAX_TX_BUFFERS = MAX_TX_BUFFERS_DEF,
	parameter int unsigned WRITE_OPCODE   = WRITE_OPCODE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	cfdtx_item_if.sink        item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              push,
	output entry_t            push_entry,
	input  qstat_t            qstat
);

	logic [15:0] offset_q;
	logic [5:0]  count_q;
	logic [2:0]  dsize_q;
	logic [4:0]  words_left_q;
	logic [4:0]  words_left_d;
	logic        wr_en;
	cfg_reg_e    reg_sel;

	logic [5:0]  count_cl;
	logic        bad_idx;
	logic [6:0]  elem;
	logic [11:0] prod;
	logic [15:0] addr;
	logic [6:0]  bytes;
	logic [4:0]  nwords;
	logic [4:0]  pwords;
	logic [31:0] hdr;
	logic [31:0] w0;
	logic [31:0] w1;

	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = cfg_reg_e'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
			count_q  <= COUNT_RST;
			dsize_q  <= DSIZE_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_OFFSET: offset_q <= pwdata[15:0];
				REG_COUNT:  count_q  <= pwdata[5:0];
				REG_DSIZE:  dsize_q  <= pwdata[2:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_OFFSET: prdata = {16'd0, offset_q};
			REG_COUNT:  prdata = {26'd0, count_q};
			REG_DSIZE:  prdata = {29'd0, dsize_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign item.ready = !qstat.full;
	assign push       = item.valid && item.ready;

	always_comb begin
		count_cl = (count_q > 6'(MAX_TX_BUFFERS)) ? 6'(MAX_TX_BUFFERS) : count_q;
		bad_idx  = ({1'b0, item.tx_buf_idx} >= count_cl);
		elem     = elem_data_bytes(dsize_q) + 7'd8;
		prod     = {5'd0, elem} * {7'd0, item.tx_buf_idx};
		addr     = 16'(16'(MRAM_BASE) + offset_q + {4'd0, prod});
		bytes    = dlc_bytes(item.dlc);
		nwords   = 5'((bytes + 7'd11) >> 2);
		pwords   = 5'((bytes + 7'd3) >> 2);
		hdr      = {8'(WRITE_OPCODE), addr, 3'd0, nwords};
		if (item.extended) begin
			w0 = {item.error_state_ind, item.extended, item.remote, item.can_id};
		end else begin
			w0 = {item.error_state_ind, item.extended, item.remote, item.can_id[10:0], 18'd0};
		end
		w1 = {item.message_marker, item.event_fifo_ctrl, 1'b0, item.fd_format,
			item.bit_rate_switch, item.dlc, 16'd0};

		push_entry   = '0;
		words_left_d = words_left_q;
		if (item.cmd == CMD_DATA) begin
			if (words_left_q == 5'd0) begin
				push_entry.err = 1'b1;
			end else begin
				words_left_d        = words_left_q - 5'd1;
				push_entry.words[0] = item.data_word;
				push_entry.last     = (words_left_q == 5'd1);
			end
		end else if (bad_idx) begin
			push_entry.err = 1'b1;
			words_left_d   = 5'd0;
		end else begin
			push_entry.words[0] = hdr;
			push_entry.words[1] = w0;
			push_entry.words[2] = w1;
			push_entry.three    = 1'b1;
			push_entry.last     = (pwords == 5'd0);
			words_left_d        = pwords;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_left_q <= 5'd0;
		end else if (push) begin
			words_left_q <= words_left_d;
		end
	end

endmodule

>>> src/cfdtx_queue.sv
module cfdtx_queue
	import cfdtx_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output qstat_t qstat
);

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.empty = (cnt_q == 2'd0);
	assign qstat.full  = (cnt_q == 2'd2);

endmodule

>>> src/cfdtx_back.sv
module cfdtx_back
	import cfdtx_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  entry_t        head,
	input  qstat_t        qstat,
	output logic          pop,
	cfdtx_result_if.source result
);

	logic [1:0] sel_q;
	logic       final_beat;

	assign final_beat      = !head.three || (sel_q == 2'd2);
	assign result.valid    = !qstat.empty;
	assign result.last     = head.last && final_beat;
	assign result.error    = head.err;
	assign pop             = result.valid && result.ready && final_beat;

	always_comb begin
		case (sel_q)
			2'd1:    result.spi_word = head.words[1];
			2'd2:    result.spi_word = head.words[2];
			default: result.spi_word = head.words[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 2'd0;
		end else if (result.valid && result.ready) begin
			sel_q <= final_beat ? 2'd0 : sel_q + 2'd1;
		end
	end

endmodule

>>> src/can_fd_tx_element_framer.sv
// Transmit buffer element framer. The item channel takes header beats (cmd 0)
// and payload beats (cmd 1); the result channel gives 32-bit SPI words.
// A valid header beat yields three result beats: the write header, W0 and W1.
// A payload beat yields one result beat, and a bad index or an unexpected
// payload beat yields one error beat with a zero word.
// Classification and word building happen in the cycle a beat is accepted,
// so the first result beat can leave in the cycle after.
// A two-entry queue sits between the front and the output sequencer.
// Payload beats stream at one per cycle while the receiver is ready; a header
// entry holds the output for its three result beats.
// When the receiver stalls, the queue fills and item ready drops after two
// pending entries; nothing is lost.
// Reset clears the queue, the expected payload count and the registers
// (offset 0, buffer count 32, data size code 0).
// Configuration goes through the APB port, registers at byte addresses 0, 4, 8.
`include "can_fd_tx_element_framer_macros.svh"

module can_fd_tx_element_framer
	import cfdtx_pkg::*;
#(
	parameter int unsigned MRAM_BASE      = MRAM_BASE_DEF,
	parameter int unsigned MAX_TX_BUFFERS = MAX_TX_BUFFERS_DEF,
	parameter int unsigned WRITE_OPCODE   = WRITE_OPCODE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	cfdtx_item_if.sink        item,
	cfdtx_result_if.source    result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t head;
	qstat_t qstat;
	logic   err_beat_ok;

	assign pready = 1'b1;

	cfdtx_front #(
		.MRAM_BASE      (MRAM_BASE),
		.MAX_TX_BUFFERS (MAX_TX_BUFFERS),
		.WRITE_OPCODE   (WRITE_OPCODE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.push       (push),
		.push_entry (push_entry),
		.qstat      (qstat)
	);

	cfdtx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	cfdtx_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

	assign err_beat_ok = !(result.valid && result.error)
		|| (result.spi_word == 32'd0 && !result.last);

	`CFDTX_ASSERT(a_err_word_zero, clk, arst_n, err_beat_ok)
	`CFDTX_ASSERT(a_queue_state, clk, arst_n, !(qstat.empty && qstat.full))
	`CFDTX_ASSERT_NEXT(a_full_after_push, clk, arst_n, !push && !qstat.full, !qstat.full)

endmodule
